[rtl/apsp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package apsp_pkg;

  localparam int MODE_W   = 2;
  localparam int VIDX_W   = 4;
  localparam int WEIGHT_W = 16;
  localparam int CFG_W    = 5;

  localparam logic [CFG_W-1:0] VCOUNT_RESET = 5'd16;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD = 2'd0,
    MODE_RUN  = 2'd1,
    MODE_READ = 2'd2
  } mode_t;

endpackage

`default_nettype wire

[rtl/apsp_cmd_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface apsp_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [apsp_pkg::MODE_W-1:0]         mode;
  logic [apsp_pkg::VIDX_W-1:0]         row;
  logic [apsp_pkg::VIDX_W-1:0]         col;
  logic signed [apsp_pkg::WEIGHT_W-1:0] weight;
  logic                                edge_absent;

  modport source (output valid, mode, row, col, weight, edge_absent, input ready);
  modport sink   (input valid, mode, row, col, weight, edge_absent, output ready);
endinterface

`default_nettype wire

[rtl/apsp_res_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface apsp_res_if #(
  parameter int DISTANCE_BITS = 24
);
  logic                            valid;
  logic                            ready;
  logic signed [DISTANCE_BITS-1:0] distance;
  logic                            unreachable;
  logic                            finished;

  modport source (output valid, distance, unreachable, finished, input ready);
  modport sink   (input valid, distance, unreachable, finished, output ready);
endinterface

`default_nettype wire

[rtl/apsp_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module apsp_ram #(
  parameter int WIDTH = 25,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/apsp_relax.sv]
`timescale 1ns / 1ps
`default_nettype none

// One relaxation step: entries are {no_path, distance}.
module apsp_relax #(
  parameter int DISTANCE_BITS = 24
) (
  input  logic [DISTANCE_BITS:0]   d_ik,
  input  logic [DISTANCE_BITS:0]   d_kj,
  input  logic [DISTANCE_BITS:0]   d_ij,
  output logic                     update,
  output logic [DISTANCE_BITS-1:0] sum
);

  localparam int DW = DISTANCE_BITS;
  localparam logic [DW-1:0] DMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] DMIN = {1'b1, {(DW-1){1'b0}}};

  logic [DW:0] wide;
  logic        ovf;

  assign wide = {d_ik[DW-1], d_ik[DW-1:0]} + {d_kj[DW-1], d_kj[DW-1:0]};
  assign ovf  = wide[DW] ^ wide[DW-1];

  always_comb begin
    if (ovf) begin
      sum = wide[DW] ? DMIN : DMAX;
    end else begin
      sum = wide[DW-1:0];
    end
  end

  // skip when either leg has no path; a path always beats no path
  assign update = !d_ik[DW] && !d_kj[DW] &&
                  (d_ij[DW] || ($signed(sum) < $signed(d_ij[DW-1:0])));

endmodule

`default_nettype wire

[rtl/all_pairs_shortest_path_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir   Payload                                   Moves
// cmd       in    mode, row, col, weight, edge_absent       load / run / read request
// result    out   distance, unreachable, finished           read answer or run completion
// cfg_wr_*  in    vertex_count (5 bits)                     write, no read-back
//
// Load: written as the command is taken. Read: through the registered RAM read and
// S_READ, which waits while an earlier result still sits in the output register.
// Run: the matrix is kept twice so d[k][j] and d[i][j] are read together, one relaxation
// per cycle, after S_IK and S_IKW fetch d[i][k] for each row. No clearing after reset:
// entries are valid once loaded.
// A finished result waits in the output register; new requests are held off only while
// a read or run is in flight.
module all_pairs_shortest_path_core #(
  parameter int MAX_VERTICES  = 16,
  parameter int DISTANCE_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [apsp_pkg::CFG_W-1:0]   cfg_wr_data,
  apsp_cmd_if.sink                     cmd,
  apsp_res_if.source                   result
);

  import apsp_pkg::*;

  localparam int DW     = DISTANCE_BITS;
  localparam int EW     = DISTANCE_BITS + 1;
  localparam int DEPTH  = MAX_VERTICES * MAX_VERTICES;
  localparam int AW     = $clog2(DEPTH);
  localparam int IDX_W  = $clog2(MAX_VERTICES);
  localparam int WW     = (DISTANCE_BITS > WEIGHT_W) ? DISTANCE_BITS : WEIGHT_W;

  localparam logic signed [DW-1:0] DMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] DMIN = {1'b1, {(DW-1){1'b0}}};

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_IK, S_IKW, S_J, S_DONE
  } state_t;

  state_t            state;
  logic [CFG_W-1:0]  vcount;
  logic [IDX_W-1:0]  k, i, j, nlast;
  logic [EW-1:0]     dik;
  logic [AW-1:0]     rd_addr;
  logic              rd_inside;

  logic              res_valid;
  logic [DW-1:0]     res_distance;
  logic              res_unreachable;
  logic              res_finished;

  logic              we;
  logic [AW-1:0]     waddr, raddr_a, raddr_b;
  logic [EW-1:0]     wdata, rdata_a, rdata_b;

  logic              relax_update;
  logic [DW-1:0]     relax_sum;

  logic              cmd_take;
  logic              cmd_inside;
  logic [AW-1:0]     cmd_addr;
  logic signed [WW-1:0] w_ext;
  logic [DW-1:0]     w_sat;
  logic              out_free;
  logic              res_set;
  logic [IDX_W-1:0]  j_inc;

  function automatic logic [AW-1:0] addr_of(input logic [IDX_W-1:0] r,
                                            input logic [IDX_W-1:0] c);
    return AW'(r) * AW'(MAX_VERTICES) + AW'(c);
  endfunction

  assign cmd.ready  = (state == S_IDLE);
  assign cmd_take   = cmd.valid && cmd.ready;
  assign cmd_inside = (int'(cmd.row) < MAX_VERTICES) && (int'(cmd.col) < MAX_VERTICES);
  assign cmd_addr   = AW'(cmd.row) * AW'(MAX_VERTICES) + AW'(cmd.col);
  assign out_free   = !res_valid || result.ready;
  assign res_set    = out_free && ((state == S_READ) || (state == S_DONE));
  assign j_inc      = j + IDX_W'(1);

  assign result.valid       = res_valid;
  assign result.distance    = res_distance;
  assign result.unreachable = res_unreachable;
  assign result.finished    = res_finished;

  // load weight into the distance range
  assign w_ext = WW'(cmd.weight);
  always_comb begin
    if (w_ext > WW'(DMAX)) begin
      w_sat = DMAX;
    end else if (w_ext < WW'(DMIN)) begin
      w_sat = DMIN;
    end else begin
      w_sat = DW'(w_ext);
    end
  end

  // memory ports
  always_comb begin
    we      = 1'b0;
    waddr   = cmd_addr;
    wdata   = {cmd.edge_absent, cmd.edge_absent ? {DW{1'b0}} : w_sat};
    raddr_a = addr_of(i, k);
    raddr_b = cmd_addr;
    unique case (state)
      S_IDLE: begin
        we = cmd_take && (mode_t'(cmd.mode) == MODE_LOAD) && cmd_inside;
      end
      S_READ: begin
        raddr_b = rd_addr;
      end
      S_IKW: begin
        raddr_a = addr_of(k, '0);
        raddr_b = addr_of(i, '0);
      end
      S_J: begin
        we      = relax_update;
        waddr   = addr_of(i, j);
        wdata   = {1'b0, relax_sum};
        raddr_a = addr_of(k, j_inc);
        raddr_b = addr_of(i, j_inc);
      end
      default: begin
      end
    endcase
  end

  // two copies: port A serves d[i][k] and d[k][j], port B d[i][j]
  apsp_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  apsp_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  apsp_relax #(.DISTANCE_BITS(DISTANCE_BITS)) u_relax (
    .d_ik   (dik),
    .d_kj   (rdata_a),
    .d_ij   (rdata_b),
    .update (relax_update),
    .sum    (relax_sum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      vcount    <= VCOUNT_RESET;
      res_valid <= 1'b0;
      k         <= '0;
      i         <= '0;
      j         <= '0;
    end else begin
      if (cfg_wr_en) begin
        vcount <= cfg_wr_data;
      end
      if (res_valid && result.ready && !res_set) begin
        res_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (cmd_take) begin
            unique case (mode_t'(cmd.mode))
              MODE_RUN: begin
                k <= '0;
                i <= '0;
                j <= '0;
                if (int'(vcount) > MAX_VERTICES) begin
                  nlast <= IDX_W'(MAX_VERTICES - 1);
                end else begin
                  nlast <= IDX_W'(vcount - CFG_W'(1));
                end
                state <= (vcount == '0) ? S_DONE : S_IK;
              end
              MODE_READ: begin
                rd_addr   <= cmd_addr;
                rd_inside <= cmd_inside;
                state     <= S_READ;
              end
              default: begin
              end
            endcase
          end
        end
        S_READ: begin
          if (out_free) begin
            res_valid       <= 1'b1;
            res_finished    <= 1'b0;
            res_unreachable <= !rd_inside || rdata_b[DW];
            res_distance    <= (rd_inside && !rdata_b[DW]) ? rdata_b[DW-1:0] : '0;
            state           <= S_IDLE;
          end
        end
        S_IK: begin
          state <= S_IKW;
        end
        S_IKW: begin
          dik   <= rdata_a;
          j     <= '0;
          state <= S_J;
        end
        S_J: begin
          // d[i][k] itself changes when j reaches k
          if (relax_update && (j == k)) begin
            dik <= {1'b0, relax_sum};
          end
          if (j == nlast) begin
            j <= '0;
            if (i == nlast) begin
              i <= '0;
              if (k == nlast) begin
                state <= S_DONE;
              end else begin
                k     <= k + IDX_W'(1);
                state <= S_IK;
              end
            end else begin
              i     <= i + IDX_W'(1);
              state <= S_IK;
            end
          end else begin
            j <= j_inc;
          end
        end
        S_DONE: begin
          if (out_free) begin
            res_valid       <= 1'b1;
            res_finished    <= 1'b1;
            res_unreachable <= 1'b0;
            res_distance    <= '0;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
